[rtl/ghss_pkg.sv]
// Shared types, constants and codes for the ground height segment search core.
// No dependencies; imported by the controller, datapath and top level.
package ghss_pkg;

    localparam int MAX_SEGMENTS  = 64;
    localparam int SEG_AW        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W         = SEG_AW + 1;
    localparam int FRAC_BITS     = 16;
    localparam int GROUND_MARGIN = 3;
    localparam logic signed [15:0] NO_GROUND = 16'sh7FFF;

    // divider retires two quotient bits per cycle over a 16-bit quotient
    localparam int QUO_BITS  = 16;
    localparam int DIV_CYCLES = QUO_BITS / 2;
    localparam int DIV_CNT_W = $clog2(DIV_CYCLES);

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REG_LINE_COUNT = 2'd0,
        REG_ORIGIN_X   = 2'd1,
        REG_ORIGIN_Y   = 2'd2
    } reg_idx_t;

    localparam logic [1:0] KIND_UNUSED = 2'b00;

    typedef struct packed
    {
        op_t                operation;
        logic [5:0]         entry_index;
        logic signed [15:0] end_a_x;
        logic signed [15:0] end_a_y;
        logic signed [15:0] end_b_x;
        logic signed [15:0] end_b_y;
        logic signed [31:0] query_x;
        logic signed [31:0] query_y;
    } req_item_t;

    typedef struct packed
    {
        logic               found;
        logic signed [15:0] ground_y;
        logic [5:0]         segment_index;
    } rsp_item_t;

    typedef struct packed
    {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [1:0]         kind;
    } seg_entry_t;

    typedef struct packed
    {
        logic [6:0]  line_count;
        logic [30:0] origin_x;
        logic [30:0] origin_y;
    } cfg_regs_t;

    typedef struct packed
    {
        logic seg_write;
        logic start_query;
        logic load_operands;
        logic multiply;
        logic div_step;
        logic update_best;
        logic next_seg;
        logic publish;
    } dp_cmd_t;

    typedef struct packed
    {
        logic seg_hit;
        logic last_seg;
        logic scan_empty;
        logic out_free;
    } dp_status_t;

    typedef enum logic [6:0]
    {
        S_IDLE   = 7'b0000001,
        S_FETCH  = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_MUL    = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_UPDATE = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

endpackage

[rtl/ghss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ghss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/ghss_controller.sv]
// Sequencer for segment writes and ground queries of the segment search core.
// Depends on ghss_pkg; drives the datapath through dp_cmd_t / dp_status_t.
module ghss_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  ghss_pkg::op_t       operation,
    input  ghss_pkg::dp_status_t status,
    output ghss_pkg::dp_cmd_t   cmd
);

    import ghss_pkg::*;

    state_t                 state_reg, state_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    if (operation == OP_QUERY)
                    begin
                        cmd.start_query = 1'b1;
                        state_next      = status.scan_empty ? S_FINISH : S_FETCH;
                    end
                    else
                    begin
                        cmd.seg_write = 1'b1;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (status.seg_hit)
                begin
                    cmd.load_operands = 1'b1;
                    state_next        = S_MUL;
                end
                else if (status.last_seg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_seg = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_MUL:
            begin
                cmd.multiply = 1'b1;
                div_cnt_next = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
                begin
                    state_next = S_UPDATE;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            S_UPDATE:
            begin
                cmd.update_best = 1'b1;
                if (status.last_seg)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_seg = 1'b1;
                    state_next   = S_FETCH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

[rtl/ghss_datapath.sv]
// Segment table, interpolation multiplier, radix-4 divider and result register.
// Depends on ghss_pkg and ghss_ram; commanded by ghss_controller.
module ghss_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ghss_pkg::req_item_t  req_item,
    input  ghss_pkg::cfg_regs_t  cfg,
    input  ghss_pkg::dp_cmd_t    cmd,
    output ghss_pkg::dp_status_t status,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output ghss_pkg::rsp_item_t  rsp_item
);

    import ghss_pkg::*;

    // segment table
    logic                     wr_en;
    seg_entry_t               wr_entry;
    seg_entry_t               rd_entry;
    logic [MAX_SEGMENTS-1:0]  valid_reg, valid_next;
    logic                     valid_rd_reg;
    logic [1:0]               kind_eff;

    // scan control
    logic [SEG_AW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]         scan_len;

    // query coordinates
    logic [31:0]              sum_x, sum_y;
    logic signed [15:0]       tx_reg, ty_reg;

    // interpolation operands
    logic signed [16:0]       dx, dy, dw;
    logic [15:0]              dxm_reg, dym_reg, den_reg;
    logic                     neg_reg;
    logic signed [15:0]       y1_reg;
    logic [31:0]              rq_reg;
    logic [31:0]              rq_one, rq_two;

    // best candidate
    logic signed [17:0]       q_ext, h_ext, floor_ext, best_ext;
    logic                     better;
    logic signed [15:0]       best_reg;
    logic [SEG_AW-1:0]        best_idx_reg;
    logic                     found_reg;

    // result register
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_item_t                rsp_item_reg;

    function automatic logic [31:0] div_bit(logic [31:0] rq, logic [15:0] d);
        logic [16:0] t;
        logic        ge;
        t  = {rq[31:16], rq[15]};
        ge = (t >= {1'b0, d});
        if (ge)
        begin
            t = t - {1'b0, d};
        end
        return {t[15:0], rq[14:0], ge};
    endfunction

    // ---- writes ----
    assign wr_en = cmd.seg_write && (int'(req_item.entry_index) < MAX_SEGMENTS);

    always_comb
    begin
        if ($signed(req_item.end_a_x) < $signed(req_item.end_b_x))
        begin
            wr_entry.left_x  = req_item.end_a_x;
            wr_entry.left_y  = req_item.end_a_y;
            wr_entry.right_x = req_item.end_b_x;
            wr_entry.right_y = req_item.end_b_y;
        end
        else
        begin
            wr_entry.left_x  = req_item.end_b_x;
            wr_entry.left_y  = req_item.end_b_y;
            wr_entry.right_x = req_item.end_a_x;
            wr_entry.right_y = req_item.end_a_y;
        end
        wr_entry.kind = {req_item.end_a_y != req_item.end_b_y,
                         req_item.end_a_x != req_item.end_b_x};
    end

    ghss_ram #(
        .WIDTH ($bits(seg_entry_t)),
        .DEPTH (MAX_SEGMENTS)
    ) u_seg_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (SEG_AW'(req_item.entry_index)),
        .wr_data (wr_entry),
        .rd_addr (idx_reg),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_en)
        begin
            valid_next[SEG_AW'(req_item.entry_index)] = 1'b1;
        end
    end

    assign kind_eff = valid_rd_reg ? rd_entry.kind : KIND_UNUSED;

    // ---- scan ----
    assign scan_len = (cfg.line_count > CNT_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                               : CNT_W'(cfg.line_count);

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start_query)
        begin
            idx_next = '0;
        end
        else if (cmd.next_seg)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    assign sum_x = req_item.query_x + {1'b0, cfg.origin_x};
    assign sum_y = req_item.query_y + {1'b0, cfg.origin_y};

    assign dx = $signed({tx_reg[15], tx_reg}) - $signed({rd_entry.left_x[15], rd_entry.left_x});
    assign dy = $signed({rd_entry.right_y[15], rd_entry.right_y})
              - $signed({rd_entry.left_y[15], rd_entry.left_y});
    assign dw = $signed({rd_entry.right_x[15], rd_entry.right_x})
              - $signed({rd_entry.left_x[15], rd_entry.left_x});

    assign status.seg_hit    = (kind_eff != KIND_UNUSED) && kind_eff[0]
                            && ($signed(tx_reg) >= $signed(rd_entry.left_x))
                            && ($signed(tx_reg) <= $signed(rd_entry.right_x));
    assign status.last_seg   = ((CNT_W'(idx_reg) + 1'b1) == scan_len);
    assign status.scan_empty = (scan_len == '0);
    assign status.out_free   = !rsp_valid_reg || !rsp_stall;

    assign rq_one = div_bit(rq_reg, den_reg);
    assign rq_two = div_bit(rq_one, den_reg);

    // ---- candidate compare ----
    assign q_ext     = $signed({2'b00, rq_reg[15:0]});
    assign h_ext     = $signed({{2{y1_reg[15]}}, y1_reg}) + (neg_reg ? -q_ext : q_ext);
    assign floor_ext = $signed({{2{ty_reg[15]}}, ty_reg}) - 18'sd3;
    assign best_ext  = $signed({{2{best_reg[15]}}, best_reg});
    assign better    = (h_ext < best_ext) && (h_ext > floor_ext);

    // ---- result register ----
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            idx_reg       <= idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        valid_rd_reg <= valid_reg[idx_reg];
        if (cmd.start_query)
        begin
            tx_reg       <= sum_x[31:FRAC_BITS];
            ty_reg       <= sum_y[31:FRAC_BITS];
            best_reg     <= NO_GROUND;
            best_idx_reg <= '0;
            found_reg    <= 1'b0;
        end
        if (cmd.load_operands)
        begin
            dxm_reg <= dx[15:0];
            dym_reg <= dy[16] ? 16'(-dy) : dy[15:0];
            neg_reg <= dy[16];
            den_reg <= dw[15:0];
            y1_reg  <= rd_entry.left_y;
        end
        if (cmd.multiply)
        begin
            rq_reg <= dxm_reg * dym_reg;
        end
        else if (cmd.div_step)
        begin
            rq_reg <= rq_two;
        end
        if (cmd.update_best && better)
        begin
            best_reg     <= h_ext[15:0];
            best_idx_reg <= idx_reg;
            found_reg    <= 1'b1;
        end
        if (cmd.publish)
        begin
            rsp_item_reg.found         <= found_reg;
            rsp_item_reg.ground_y      <= best_reg;
            rsp_item_reg.segment_index <= 6'(best_idx_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

[rtl/ground_height_segment_search_core.sv]
// Top level of the ground height segment search core: APB register file,
// controller and datapath. Depends on ghss_pkg, ghss_controller, ghss_datapath.
//
// Usage:
//   req channel (req_valid / req_stall / req_item) carries one item per
//   handshake: operation OP_WRITE stores a segment at entry_index, OP_QUERY
//   asks for the ground height under query_x/query_y plus the origin.
//   rsp channel (rsp_valid / rsp_stall / rsp_item) returns one item per query;
//   writes give none.
//   A write does not stall the req channel. A query holds req_stall high
//   while it scans n = min(line_count, 64) entries: every entry is read
//   from RAM and span-checked; a non-vertical entry whose x span holds the
//   query column also goes through multiply, a 2-bit-per-cycle divider, compare.
//   The result waits in an output register; the next item is accepted while
//   it waits, but a second query finishes only once the first is taken.
//   Reset clears the control state, the config registers and the entry valid
//   bits, so every entry reads as unused. Config is written over APB at
//   0x0 line_count, 0x4 origin_x, 0x8 origin_y; pready is always high.
module ground_height_segment_search_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                req_valid,
    output logic                req_stall,
    input  ghss_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output ghss_pkg::rsp_item_t rsp_item
);

    import ghss_pkg::*;

    cfg_regs_t   cfg_reg, cfg_next;
    reg_idx_t    reg_sel;
    dp_cmd_t     cmd;
    dp_status_t  status;

    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite && pready)
        begin
            unique case (reg_sel)
                REG_LINE_COUNT: cfg_next.line_count = pwdata[6:0];
                REG_ORIGIN_X:   cfg_next.origin_x   = pwdata[30:0];
                REG_ORIGIN_Y:   cfg_next.origin_y   = pwdata[30:0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_LINE_COUNT: prdata = {25'd0, cfg_reg.line_count};
            REG_ORIGIN_X:   prdata = {1'b0, cfg_reg.origin_x};
            REG_ORIGIN_Y:   prdata = {1'b0, cfg_reg.origin_y};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ghss_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .operation (req_item.operation),
        .status    (status),
        .cmd       (cmd)
    );

    ghss_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .cfg       (cfg_reg),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

`ifndef SYNTHESIS
    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> status.out_free)
        else $error("result published over an untaken item");

    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.seg_write, cmd.start_query, cmd.load_operands, cmd.multiply,
                  cmd.div_step, cmd.update_best, cmd.publish}))
        else $error("conflicting datapath commands");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_query |=> req_stall)
        else $error("request side open during a query");
`endif

endmodule

[test/ground_height_segment_search_core_tb.sv]
// Self-checking testbench for ground_height_segment_search_core: segment writes and
// ground queries over valid/stall channels, register setup over APB.
// Depends on ghss_pkg and the core RTL.
`timescale 1ns / 100ps

module ground_height_segment_search_core_tb;
    import ghss_pkg::*;

    localparam int LIMIT_CYCLES  = 4000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam logic [3:0] ADDR_UNMAPPED = 4'hC;

    typedef struct packed
    {
        logic      setup;
        cfg_regs_t cfg;
        logic      typed;
        rsp_item_t want;
        req_item_t item;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_stall;
    req_item_t   req_item;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_item_t   rsp_item;

    seg_entry_t seg_table [MAX_SEGMENTS];
    cfg_regs_t  cur_cfg;
    rsp_item_t  pending_ground [$];
    dir_row_t   dir_rows [$];

    int fail_count;
    int n_writes;
    int n_queries;
    int n_found;
    int n_settings;
    int cycles;
    int sender_idle_pct;
    int receiver_stall_pct;

    ground_height_segment_search_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // integer pixel of a 16.16 coordinate after the origin is added, sum wrapped
    function automatic int world_pixel(logic [31:0] q, logic [30:0] org);
        logic [31:0] s;
        s = q + {1'b0, org};
        return $signed(s) >>> FRAC_BITS;
    endfunction

    function automatic rsp_item_t ground_lookup(req_item_t it);
        rsp_item_t r;
        int        tx;
        int        ty;
        int        best;
        int        best_idx;
        int        n;
        int        x1;
        int        y1;
        int        x2;
        int        y2;
        int        h;
        longint    num;
        logic      hit;
        tx       = world_pixel(it.query_x, cur_cfg.origin_x);
        ty       = world_pixel(it.query_y, cur_cfg.origin_y);
        best     = int'(NO_GROUND);
        best_idx = 0;
        hit      = 1'b0;
        n        = (cur_cfg.line_count > MAX_SEGMENTS) ? MAX_SEGMENTS : cur_cfg.line_count;
        for (int i = 0; i < n; i++)
        begin
            if (seg_table[i].kind == KIND_UNUSED)
                continue;
            x1 = int'(seg_table[i].left_x);
            y1 = int'(seg_table[i].left_y);
            x2 = int'(seg_table[i].right_x);
            y2 = int'(seg_table[i].right_y);
            if (x1 == x2 || tx < x1 || tx > x2)
                continue;
            num = longint'(tx - x1) * longint'(y2 - y1);
            h   = y1 + int'(num / longint'(x2 - x1));
            if (h < best && h > ty - GROUND_MARGIN)
            begin
                best     = h;
                best_idx = i;
                hit      = 1'b1;
            end
        end
        r.found         = hit;
        r.ground_y      = best[15:0];
        r.segment_index = best_idx[5:0];
        return r;
    endfunction

    function automatic void seg_store(req_item_t it);
        seg_entry_t e;
        if ($signed(it.end_a_x) < $signed(it.end_b_x))
        begin
            e.left_x  = it.end_a_x;
            e.left_y  = it.end_a_y;
            e.right_x = it.end_b_x;
            e.right_y = it.end_b_y;
        end
        else
        begin
            e.left_x  = it.end_b_x;
            e.left_y  = it.end_b_y;
            e.right_x = it.end_a_x;
            e.right_y = it.end_a_y;
        end
        e.kind = {it.end_a_y != it.end_b_y, it.end_a_x != it.end_b_x};
        seg_table[it.entry_index] = e;
    endfunction

    function automatic logic [15:0] near(int k);
        int v;
        v = $urandom_range(2 * k);
        v = v - k;
        return v[15:0];
    endfunction

    // mostly segments and query points in one small window so queries hit
    function automatic req_item_t rand_item();
        req_item_t it;
        int        s;
        it.entry_index = 6'($urandom_range(63));
        it.end_a_x     = 16'($urandom_range(65535));
        it.end_a_y     = 16'($urandom_range(65535));
        it.end_b_x     = 16'($urandom_range(65535));
        it.end_b_y     = 16'($urandom_range(65535));
        it.query_x     = $urandom;
        it.query_y     = $urandom;
        if ($urandom_range(99) < 40)
        begin
            it.operation = OP_WRITE;
            s = $urandom_range(99);
            if (s < 75)
            begin
                it.end_a_x = near(200);
                it.end_a_y = near(200);
                it.end_b_x = near(200);
                it.end_b_y = near(200);
            end
            else if (s < 87)
                ;
            else if (s < 93)
            begin
                it.end_a_x = near(200);
                it.end_b_x = it.end_a_x;
            end
            else if (s < 97)
            begin
                it.end_a_x = near(200);
                it.end_b_x = near(200);
                it.end_b_y = it.end_a_y;
            end
            else
            begin
                it.end_b_x = it.end_a_x;
                it.end_b_y = it.end_a_y;
            end
        end
        else
        begin
            it.operation = OP_QUERY;
            if ($urandom_range(99) < 85)
            begin
                it.query_x = {near(210), 16'($urandom_range(65535))} - {1'b0, cur_cfg.origin_x};
                it.query_y = {near(260), 16'($urandom_range(65535))} - {1'b0, cur_cfg.origin_y};
            end
        end
        return it;
    endfunction

    task automatic add_write(int idx, int ax, int ay, int bx, int by);
        dir_row_t row;
        row                  = '0;
        row.item             = rand_item();
        row.item.operation   = OP_WRITE;
        row.item.entry_index = 6'(idx);
        row.item.end_a_x     = 16'(ax);
        row.item.end_a_y     = 16'(ay);
        row.item.end_b_x     = 16'(bx);
        row.item.end_b_y     = 16'(by);
        dir_rows.push_back(row);
    endtask

    task automatic add_query(logic [31:0] qx, logic [31:0] qy, logic typed,
                             logic found, logic [15:0] gy, logic [5:0] idx);
        dir_row_t row;
        row                    = '0;
        row.item               = rand_item();
        row.item.operation     = OP_QUERY;
        row.item.query_x       = qx;
        row.item.query_y       = qy;
        row.typed              = typed;
        row.want.found         = found;
        row.want.ground_y      = gy;
        row.want.segment_index = idx;
        dir_rows.push_back(row);
    endtask

    task automatic add_setup(logic [6:0] lc, logic [30:0] ox, logic [30:0] oy);
        dir_row_t row;
        row                = '0;
        row.setup          = 1'b1;
        row.cfg.line_count = lc;
        row.cfg.origin_x   = ox;
        row.cfg.origin_y   = oy;
        dir_rows.push_back(row);
    endtask

    task automatic send_item(req_item_t it, logic typed, rsp_item_t want);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        if (it.operation == OP_WRITE)
        begin
            seg_store(it);
            n_writes++;
        end
        else
        begin
            pending_ground.push_back(typed ? want : ground_lookup(it));
            n_queries++;
        end
    endtask

    task automatic drain_block();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_ground.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (!wr && prdata !== data)
        begin
            $error("register 0x%0h: expected 0x%0h, actual 0x%0h", addr, data, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(cfg_regs_t c);
        drain_block();
        apb_access(1'b1, {REG_LINE_COUNT, 2'b00}, {25'd0, c.line_count});
        apb_access(1'b1, {REG_ORIGIN_X, 2'b00}, {1'b0, c.origin_x});
        apb_access(1'b1, {REG_ORIGIN_Y, 2'b00}, {1'b0, c.origin_y});
        apb_access(1'b1, ADDR_UNMAPPED, $urandom);
        cur_cfg = c;
        n_settings++;
        apb_access(1'b0, {REG_LINE_COUNT, 2'b00}, {25'd0, c.line_count});
        apb_access(1'b0, {REG_ORIGIN_X, 2'b00}, {1'b0, c.origin_x});
        apb_access(1'b0, {REG_ORIGIN_Y, 2'b00}, {1'b0, c.origin_y});
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < receiver_stall_pct);

    always @(posedge clk)
    begin : result_check
        rsp_item_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_ground.size() == 0)
            begin
                $error("unexpected result: found %0d ground_y %0d segment_index %0d",
                       rsp_item.found, $signed(rsp_item.ground_y), rsp_item.segment_index);
                fail_count++;
            end
            else
            begin
                want = pending_ground.pop_front();
                check_field("found", int'(want.found), int'(rsp_item.found));
                check_field("ground_y", int'(want.ground_y), int'(rsp_item.ground_y));
                check_field("segment_index", int'(want.segment_index),
                            int'(rsp_item.segment_index));
                if (rsp_item.found)
                    n_found++;
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("no progress after %0d cycles, %0d results outstanding",
               LIMIT_CYCLES, pending_ground.size());
        $display("ground_height_segment_search_core test failed");
        $finish;
    end

    initial
    begin
        cfg_regs_t c;
        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_valid          = 1'b0;
        req_item           = '0;
        rsp_stall          = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        fail_count         = 0;
        n_writes           = 0;
        n_queries          = 0;
        n_found            = 0;
        n_settings         = 0;
        cur_cfg            = '0;
        for (int i = 0; i < MAX_SEGMENTS; i++)
            seg_table[i] = '0;

        // nothing is scanned straight out of reset
        add_query(32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_GROUND, 6'd0);
        add_write(0, 0, 100, 100, 0);
        add_write(1, 50, 40, -50, 40);
        add_write(2, 10, 0, 10, 50);
        add_write(3, 20, 20, 20, 20);
        add_write(63, -32768, -32768, 32767, 32767);
        add_write(4, -50, 40, 50, 40);
        add_setup(7'd64, 31'd0, 31'd0);
        add_query(32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h000A_0000, 32'h0000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        // margin boundary, then a tie between two equal horizontals
        add_query(32'h001E_0000, 32'h002B_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h001E_0000, 32'h002A_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_GROUND, 6'd0);
        add_query(32'h0000_FFFF, 32'hFFFF_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_setup(7'd127, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        add_query(32'h0000_0001, 32'h8000_0001, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_setup(7'd1, 31'd0, 31'd0);
        add_query(32'h0000_0000, 32'hFF00_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_query(32'h0096_0000, 32'h0000_0000, 1'b0, 1'b0, 16'd0, 6'd0);
        add_write(0, 5, 5, 5, 5);
        add_query(32'h0000_0000, 32'hFF00_0000, 1'b0, 1'b0, 16'd0, 6'd0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].setup)
                set_config(dir_rows[i].cfg);
            else
                send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            c.line_count = 7'd64;
            c.origin_x   = '0;
            c.origin_y   = '0;
            case (p)
                1:
                begin
                    c.line_count = 7'd127;
                    c.origin_x   = 31'($urandom);
                    c.origin_y   = 31'($urandom);
                end
                2: c.line_count = 7'($urandom_range(64, 2));
                3: c.line_count = 7'd0;
                4: c.line_count = 7'd1;
                5:
                begin
                    c.origin_x = '1;
                    c.origin_y = '1;
                end
                6:
                begin
                    c.line_count = 7'($urandom_range(127, 1));
                    c.origin_x   = 31'($urandom);
                    c.origin_y   = 31'($urandom);
                end
                default: ;
            endcase
            set_config(c);
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 72;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 72;
                end
                default:
                begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if ($urandom_range(99) == 0)
                    drain_block();
                send_item(rand_item(), 1'b0, '0);
            end
        end

        drain_block();
        $display("Covered %0d segment writes and %0d ground queries (%0d found ground)",
                 n_writes, n_queries, n_found);
        $display("across %0d register settings in %0d cycles", n_settings, cycles);
        if (fail_count == 0)
            $display("ground_height_segment_search_core test passed");
        else
            $display("ground_height_segment_search_core test failed");
        $finish;
    end

endmodule

[ground_height_segment_search_core.f]
rtl/ghss_pkg.sv
rtl/ghss_ram.sv
rtl/ghss_controller.sv
rtl/ghss_datapath.sv
rtl/ground_height_segment_search_core.sv
test/ground_height_segment_search_core_tb.sv
